FILE: src/acp_pkg.sv
// Shared types, tables and round functions for the AES-128 CBC PKCS7 block.
package acp_pkg;

    localparam int BLOCK_W   = 128;
    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 5;
    localparam int ROUND_W   = 4;
    localparam int NUM_ROUNDS = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [COUNT_W-1:0] FULL_BYTES = 5'd16;
    localparam logic [7:0] PAD_FULL = 8'h10;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0]  block_high;
        logic [WORD_W-1:0]  block_low;
        logic [COUNT_W-1:0] byte_count;
        logic               first_block;
        logic               last_block;
    } acp_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  out_high;
        logic [WORD_W-1:0]  out_low;
        logic [COUNT_W-1:0] valid_bytes;
        logic               pad_error;
        logic               last_result;
    } acp_out_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic               first;
        logic               decrypt;
        logic               last;
        logic               check;
    } acp_job_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] key;
        logic [BLOCK_W-1:0] iv;
        logic               decrypt;
    } acp_cfg_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [0:9] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    typedef logic [7:0] byte_table_t [0:255];

    function automatic byte_table_t build_inv();
        byte_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam byte_table_t INV_SBOX = build_inv();

    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic fin);
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3;
        logic [BLOCK_W-1:0] o;
        for (int i = 0; i < 16; i++)
        begin
            t[i] = SBOX[get_byte(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4))];
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!fin)
            begin
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[BLOCK_W-1-8*i -: 8] = t[i] ^ get_byte(rk, i);
        end
        return o;
    endfunction

    function automatic logic [7:0] m9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic logic [7:0] m11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic logic [7:0] m13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic logic [7:0] m14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic mix);
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3;
        logic [BLOCK_W-1:0] o;
        for (int i = 0; i < 16; i++)
        begin
            t[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)] = INV_SBOX[get_byte(s, i)];
        end
        for (int i = 0; i < 16; i++)
        begin
            t[i] = t[i] ^ get_byte(rk, i);
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (mix)
            begin
                t[4*c]   = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
                t[4*c+1] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
                t[4*c+2] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
                t[4*c+3] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[BLOCK_W-1-8*i -: 8] = t[i];
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] tw, w0, w1, w2, w3;
        tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ tw;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

FILE: src/acp_front.sv
// Front end: accepts input beats, applies encrypt padding and issues cipher jobs.
module acp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  acp_pkg::acp_in_t   item,
    input  logic               decrypt,
    output logic               q_push,
    output acp_pkg::acp_job_t  q_data,
    input  logic               q_full
);
    import acp_pkg::*;

    logic               pend_reg, pend_next;
    logic               take;
    logic [COUNT_W-1:0] cnt;
    logic [7:0]         pad_val;
    logic [BLOCK_W-1:0] padded;
    logic               short_last;
    acp_job_t           job_a, job_pad;

    assign full = pend_reg || q_full;
    assign take = push && !full;

    always_comb
    begin
        cnt = (item.byte_count > FULL_BYTES) ? FULL_BYTES : item.byte_count;
        pad_val = 8'(FULL_BYTES - cnt);
        short_last = item.last_block && (cnt < FULL_BYTES);
        padded = {item.block_high, item.block_low};
        for (int i = 0; i < 16; i++)
        begin
            if (short_last && (5'(i) >= cnt))
            begin
                padded[BLOCK_W-1-8*i -: 8] = pad_val;
            end
        end
        job_a.data    = decrypt ? {item.block_high, item.block_low} : padded;
        job_a.first   = item.first_block;
        job_a.decrypt = decrypt;
        job_a.last    = decrypt ? item.last_block : short_last;
        job_a.check   = decrypt && item.last_block;
        job_pad.data    = {16{PAD_FULL}};
        job_pad.first   = 1'b0;
        job_pad.decrypt = 1'b0;
        job_pad.last    = 1'b1;
        job_pad.check   = 1'b0;
        q_push = take || (pend_reg && !q_full);
        q_data = pend_reg ? job_pad : job_a;
        pend_next = pend_reg;
        if (pend_reg && !q_full)
        begin
            pend_next = 1'b0;
        end
        else if (take && !decrypt && item.last_block && !short_last)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

FILE: src/acp_queue.sv
// Two-entry job queue between front end and cipher back end.
module acp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  acp_pkg::acp_job_t  wr_data,
    output logic               q_full,
    input  logic               rd,
    output acp_pkg::acp_job_t  rd_data,
    output logic               q_empty
);
    import acp_pkg::*;

    acp_job_t   mem [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign q_full  = (cnt_reg == 2'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !q_full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd && !q_empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
        end
    end

endmodule

FILE: src/acp_back.sv
// Back end: key expansion, iterated AES rounds, CBC chaining and result register.
module acp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  acp_pkg::acp_cfg_t  cfg,
    input  acp_pkg::acp_job_t  q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output acp_pkg::acp_out_t  result
);
    import acp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_KEY, S_LOAD, S_ROUND, S_DONE} state_t;

    state_t             st_reg;
    acp_job_t           job_reg;
    logic [BLOCK_W-1:0] state_reg, chain_reg, kw_reg, kw_next;
    logic [BLOCK_W-1:0] rk_reg [NUM_ROUNDS+1];
    logic [ROUND_W-1:0] cnt_reg;
    logic               out_valid_reg, out_valid_next;
    acp_out_t           out_reg;
    logic [BLOCK_W-1:0] res;
    logic [7:0]         p;
    logic               bad;
    logic               out_free;

    assign q_pop    = (st_reg == S_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign kw_next  = key_step(kw_reg, RCON[cnt_reg - 4'd1]);
    assign out_valid_next = ((st_reg == S_DONE) && out_free) ? 1'b1 :
                            ((pop && out_valid_reg) ? 1'b0 : out_valid_reg);

    always_comb
    begin
        res = job_reg.decrypt ? (state_reg ^ chain_reg) : state_reg;
        p = res[7:0];
        bad = (p == 8'd0) || (p > 8'd16);
        for (int i = 0; i < 16; i++)
        begin
            if ((8'(i) >= 8'd16 - p) && (res[BLOCK_W-1-8*i -: 8] != p))
            begin
                bad = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && !q_empty && q_data.first)
        begin
            rk_reg[0] <= cfg.key;
        end
        if (st_reg == S_KEY)
        begin
            rk_reg[cnt_reg] <= kw_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg <= q_data;
                        if (q_data.first)
                        begin
                            kw_reg    <= cfg.key;
                            chain_reg <= cfg.iv;
                            cnt_reg   <= 4'd1;
                            st_reg    <= S_KEY;
                        end
                        else
                        begin
                            st_reg <= S_LOAD;
                        end
                    end
                end
                S_KEY:
                begin
                    kw_reg <= kw_next;
                    if (cnt_reg == ROUND_W'(NUM_ROUNDS))
                    begin
                        st_reg <= S_LOAD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_LOAD:
                begin
                    if (job_reg.decrypt)
                    begin
                        state_reg <= job_reg.data ^ rk_reg[NUM_ROUNDS];
                        cnt_reg   <= ROUND_W'(NUM_ROUNDS - 1);
                    end
                    else
                    begin
                        state_reg <= job_reg.data ^ chain_reg ^ rk_reg[0];
                        cnt_reg   <= 4'd1;
                    end
                    st_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (job_reg.decrypt)
                    begin
                        state_reg <= dec_round(state_reg, rk_reg[cnt_reg], cnt_reg != 4'd0);
                        if (cnt_reg == 4'd0)
                        begin
                            st_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 4'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= enc_round(state_reg, rk_reg[cnt_reg],
                                               cnt_reg == ROUND_W'(NUM_ROUNDS));
                        if (cnt_reg == ROUND_W'(NUM_ROUNDS))
                        begin
                            st_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 4'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.out_high    <= res[127:64];
                        out_reg.out_low     <= res[63:0];
                        out_reg.last_result <= job_reg.last;
                        if (job_reg.check && !bad)
                        begin
                            out_reg.valid_bytes <= FULL_BYTES - p[4:0];
                            out_reg.pad_error   <= 1'b0;
                        end
                        else
                        begin
                            out_reg.valid_bytes <= FULL_BYTES;
                            out_reg.pad_error   <= job_reg.check;
                        end
                        chain_reg <= job_reg.decrypt ? job_reg.data : state_reg;
                        st_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/aes128_cbc_pkcs7.sv
// AES-128 CBC engine with PKCS7 padding: top level, configuration registers and wiring.
// Each block passes through the back end in order: pop from queue, load, ten rounds through one
// shared round unit, result write; a block that starts a message first runs round key
// expansion. A full last block when encrypting yields a second, padding-only result.
// Input and results are queue-style (push/full, pop/empty); configuration is written through
// wr_en, wr_index and wr_data; the user must write it only while the block is idle (not enforced).
module aes128_cbc_pkcs7 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  acp_pkg::acp_in_t  item,
    output logic              empty,
    input  logic              pop,
    output acp_pkg::acp_out_t result,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [63:0]       wr_data
);
    import acp_pkg::*;

    logic [WORD_W-1:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic              mode_reg;
    acp_cfg_t          cfg;
    logic              q_push, q_full, q_pop, q_empty;
    acp_job_t          q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY_HIGH: key_high_reg <= wr_data;
                REG_KEY_LOW:  key_low_reg  <= wr_data;
                REG_IV_HIGH:  iv_high_reg  <= wr_data;
                REG_IV_LOW:   iv_low_reg   <= wr_data;
                REG_MODE:     mode_reg     <= wr_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg.key     = {key_high_reg, key_low_reg};
    assign cfg.iv      = {iv_high_reg, iv_low_reg};
    assign cfg.decrypt = mode_reg;

    acp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .decrypt (mode_reg),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_full  (q_full)
    );

    acp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_in),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (q_out),
        .q_empty (q_empty)
    );

    acp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_data  (q_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

FILE: test/aes128_cbc_pkcs7_tb.sv
// Testbench for the AES-128 CBC PKCS7 engine: directed and random messages, self-checking.
`timescale 1ns / 100ps

module aes128_cbc_pkcs7_tb;
    import acp_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    acp_in_t item;
    logic empty;
    logic pop;
    acp_out_t result;
    logic wr_en;
    logic [2:0] wr_index;
    logic [63:0] wr_data;

    aes128_cbc_pkcs7 dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    logic [7:0] sb [0:255];
    logic [7:0] isb [0:255];
    logic [7:0] rc [0:9];
    logic [127:0] cipher_key;
    logic [127:0] cipher_iv;
    logic decrypting;
    logic [127:0] chain;
    logic [127:0] rkeys [0:10];
    acp_out_t expected_beats [$];
    int errors;
    int idle_cycles;
    int rx_max_wait;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = dbl(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    task automatic queue_beat(input acp_out_t b);
        expected_beats = {expected_beats, b};
    endtask

    task automatic expand_round_keys();
        logic [7:0] w [0:175];
        logic [7:0] t [0:3];
        logic [7:0] x;
        for (int i = 0; i < 16; i++)
            w[i] = byte_at(cipher_key, i);
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[i - 4 + j];
            if (i % 16 == 0)
            begin
                x = t[0];
                t[0] = sb[t[1]] ^ rc[i / 16 - 1];
                t[1] = sb[t[2]];
                t[2] = sb[t[3]];
                t[3] = sb[x];
            end
            for (int j = 0; j < 4; j++)
                w[i + j] = w[i - 16 + j] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++)
                rkeys[r][127 - 8 * i -: 8] = w[16 * r + i];
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            s[i] = byte_at(blk, i) ^ byte_at(rkeys[0], i);
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                t[i] = sb[s[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
            for (int c = 0; c < 4; c++)
            begin
                if (r < 10)
                begin
                    s[4*c]   = gf_mul(t[4*c], 8'd2) ^ gf_mul(t[4*c+1], 8'd3) ^ t[4*c+2]
                               ^ t[4*c+3];
                    s[4*c+1] = t[4*c] ^ gf_mul(t[4*c+1], 8'd2) ^ gf_mul(t[4*c+2], 8'd3)
                               ^ t[4*c+3];
                    s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2], 8'd2)
                               ^ gf_mul(t[4*c+3], 8'd3);
                    s[4*c+3] = gf_mul(t[4*c], 8'd3) ^ t[4*c+1] ^ t[4*c+2]
                               ^ gf_mul(t[4*c+3], 8'd2);
                end
                else
                begin
                    for (int j = 0; j < 4; j++)
                        s[4*c+j] = t[4*c+j];
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = s[i] ^ byte_at(rkeys[r], i);
        end
        for (int i = 0; i < 16; i++)
            o[127 - 8 * i -: 8] = s[i];
        return o;
    endfunction

    function automatic logic [127:0] aes_decrypt(input logic [127:0] blk);
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            s[i] = byte_at(blk, i) ^ byte_at(rkeys[10], i);
        for (int r = 9; r >= 0; r--)
        begin
            for (int i = 0; i < 16; i++)
                t[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)] = isb[s[i]];
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ byte_at(rkeys[r], i);
            if (r > 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                               ^ gf_mul(a3, 8'd9);
                    s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                               ^ gf_mul(a3, 8'd13);
                    s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                               ^ gf_mul(a3, 8'd11);
                    s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                               ^ gf_mul(a3, 8'd14);
                end
            end
        end
        for (int i = 0; i < 16; i++)
            o[127 - 8 * i -: 8] = s[i];
        return o;
    endfunction

    function automatic acp_out_t make_beat(input logic [127:0] d, input logic [4:0] vb,
                                           input logic err, input logic lst);
        acp_out_t b;
        b.out_high = d[127:64];
        b.out_low = d[63:0];
        b.valid_bytes = vb;
        b.pad_error = err;
        b.last_result = lst;
        return b;
    endfunction

    task automatic predict_cbc(input acp_in_t it);
        logic [127:0] blk;
        logic [127:0] plain;
        int cnt;
        int p;
        logic bad;
        if (it.first_block)
        begin
            expand_round_keys();
            chain = cipher_iv;
        end
        cnt = (it.byte_count > 16) ? 16 : it.byte_count;
        blk = {it.block_high, it.block_low};
        if (!decrypting)
        begin
            if (it.last_block && cnt < 16)
            begin
                for (int i = cnt; i < 16; i++)
                    blk[127 - 8 * i -: 8] = 8'(16 - cnt);
                chain = aes_encrypt(blk ^ chain);
                queue_beat(make_beat(chain, FULL_BYTES, 1'b0, 1'b1));
            end
            else
            begin
                chain = aes_encrypt(blk ^ chain);
                queue_beat(make_beat(chain, FULL_BYTES, 1'b0, 1'b0));
                if (it.last_block)
                begin
                    chain = aes_encrypt({16{PAD_FULL}} ^ chain);
                    queue_beat(make_beat(chain, FULL_BYTES, 1'b0, 1'b1));
                end
            end
        end
        else
        begin
            plain = aes_decrypt(blk) ^ chain;
            chain = blk;
            if (it.last_block)
            begin
                p = plain[7:0];
                bad = (p == 0 || p > 16);
                if (!bad)
                    for (int i = 16 - p; i < 16; i++)
                        if (plain[127 - 8 * i -: 8] != 8'(p))
                            bad = 1'b1;
                if (bad)
                    queue_beat(make_beat(plain, FULL_BYTES, 1'b1, 1'b1));
                else
                    queue_beat(make_beat(plain, 5'(16 - p), 1'b0, 1'b1));
            end
            else
                queue_beat(make_beat(plain, FULL_BYTES, 1'b0, 1'b0));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        case (idx)
            REG_KEY_HIGH: cipher_key[127:64] = val;
            REG_KEY_LOW:  cipher_key[63:0] = val;
            REG_IV_HIGH:  cipher_iv[127:64] = val;
            REG_IV_LOW:   cipher_iv[63:0] = val;
            REG_MODE:     decrypting = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic setup_cipher(input logic [127:0] k, input logic [127:0] v, input logic dec);
        drain();
        write_reg(REG_KEY_HIGH, k[127:64]);
        write_reg(REG_KEY_LOW, k[63:0]);
        write_reg(REG_IV_HIGH, v[127:64]);
        write_reg(REG_IV_LOW, v[63:0]);
        write_reg(REG_MODE, {63'd0, dec});
        wr_en <= 1'b0;
    endtask

    task automatic send_block(input logic [127:0] d, input logic [4:0] cnt,
                              input logic fst, input logic lst, input int gap);
        acp_in_t it;
        it.block_high = d[127:64];
        it.block_low = d[63:0];
        it.byte_count = cnt;
        it.first_block = fst;
        it.last_block = lst;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_cbc(it);
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    endfunction

    // Build a valid padded block so decrypt sees good padding; the caller encrypts it in the model.
    function automatic logic [127:0] padded_plain(input int p);
        logic [127:0] b;
        b = rand_block();
        for (int i = 16 - p; i < 16; i++)
            b[127 - 8 * i -: 8] = 8'(p);
        return b;
    endfunction

    task automatic send_message(input int nblk, input int gapmode);
        logic [4:0] cnt;
        for (int i = 0; i < nblk; i++)
        begin
            cnt = (i == nblk - 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 31));
            send_block(rand_block(), cnt, i == 0, i == nblk - 1,
                       gapmode ? draw_gap() : 0);
        end
    endtask

    // Decrypt a message whose ciphertext is built in the model, with good padding mostly.
    task automatic send_cipher_message(input int nblk);
        logic [127:0] ch;
        logic [127:0] ct;
        logic [127:0] pl;
        expand_round_keys();
        ch = cipher_iv;
        for (int i = 0; i < nblk; i++)
        begin
            if (i == nblk - 1 && $urandom_range(0, 4) != 0)
                pl = padded_plain($urandom_range(1, 16));
            else
                pl = rand_block();
            ct = aes_encrypt(pl ^ ch);
            ch = ct;
            send_block(ct, 5'($urandom_range(0, 31)), i == 0, i == nblk - 1, draw_gap());
        end
    endtask

    task automatic test_encrypt_directed();
        setup_cipher(128'h2b7e151628aed2a6abf7158809cf4f3c,
                     128'h000102030405060708090a0b0c0d0e0f, 1'b0);
        send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b1, 1'b0, 0);
        send_block(128'hae2d8a571e03ac9c9eb76fac45af8e51, 5'd16, 1'b0, 1'b1, 0);
        send_block({128{1'b1}}, 5'd0, 1'b1, 1'b1, 0);
        send_block(128'd0, 5'd1, 1'b1, 1'b1, 0);
        send_block({128{1'b1}}, 5'd15, 1'b1, 1'b1, 0);
        send_block(128'd0, 5'd31, 1'b1, 1'b1, 0);
        send_block(rand_block(), 5'd17, 1'b0, 1'b0, 0);
        send_block(rand_block(), 5'd3, 1'b0, 1'b1, 0);
        setup_cipher({128{1'b1}}, {128{1'b1}}, 1'b0);
        send_block({128{1'b1}}, 5'd16, 1'b1, 1'b1, 0);
    endtask

    task automatic test_decrypt_directed();
        setup_cipher(128'h2b7e151628aed2a6abf7158809cf4f3c,
                     128'h000102030405060708090a0b0c0d0e0f, 1'b1);
        send_cipher_message(1);
        send_cipher_message(3);
        send_block(128'd0, 5'd0, 1'b1, 1'b1, 0);
        send_block({128{1'b1}}, 5'd16, 1'b1, 1'b1, 0);
        send_block(rand_block(), 5'd16, 1'b0, 1'b0, 0);
        send_block(rand_block(), 5'd16, 1'b0, 1'b1, 0);
        setup_cipher(128'd0, 128'd0, 1'b1);
        send_cipher_message(2);
    endtask

    task automatic test_mode_switch();
        setup_cipher(rand_block(), rand_block(), 1'b0);
        send_block(rand_block(), 5'd16, 1'b1, 1'b0, 0);
        setup_cipher(cipher_key, cipher_iv, 1'b1);
        send_block(rand_block(), 5'd16, 1'b0, 1'b1, 0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        sent = 0;
        while (sent < 1200)
        begin
            setup_cipher(rand_block(), rand_block(), $urandom_range(0, 1));
            rx_max_wait = ($urandom_range(0, 3) == 0) ? 0 : 10;
            for (int m = 0; m < 8; m++)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
                if (decrypting && $urandom_range(0, 3) != 0)
                    send_cipher_message(n);
                else
                    send_message(n, 1);
                sent += n;
            end
        end
        rx_max_wait = 10;
    endtask

    initial
    begin
        sb = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        rc = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
        for (int i = 0; i < 256; i++)
            isb[sb[i]] = 8'(i);
    end

    // Pop side: random stalls, check every beat against the oldest expectation.
    initial
    begin
        int wait_n;
        acp_out_t exp_beat;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = $urandom_range(0, rx_max_wait);
            if (wait_n > 0)
            begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat exp none got %h", $time, result);
                errors++;
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (result.out_high !== exp_beat.out_high)
                begin
                    $display("%0t: out_high exp %h got %h", $time, exp_beat.out_high,
                             result.out_high);
                    errors++;
                end
                if (result.out_low !== exp_beat.out_low)
                begin
                    $display("%0t: out_low exp %h got %h", $time, exp_beat.out_low,
                             result.out_low);
                    errors++;
                end
                if (result.valid_bytes !== exp_beat.valid_bytes)
                begin
                    $display("%0t: valid_bytes exp %0d got %0d", $time, exp_beat.valid_bytes,
                             result.valid_bytes);
                    errors++;
                end
                if (result.pad_error !== exp_beat.pad_error)
                begin
                    $display("%0t: pad_error exp %b got %b", $time, exp_beat.pad_error,
                             result.pad_error);
                    errors++;
                end
                if (result.last_result !== exp_beat.last_result)
                begin
                    $display("%0t: last_result exp %b got %b", $time, exp_beat.last_result,
                             result.last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        rx_max_wait = 10;
        cipher_key = '0;
        cipher_iv = '0;
        decrypting = 1'b0;
        chain = '0;
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        wr_en <= 1'b0;
        wr_index <= REG_KEY_HIGH;
        wr_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encrypt_directed();
        test_decrypt_directed();
        test_mode_switch();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
